/* design/spv_pkg.sv */
// Shared types, codes and constants of the sample playback voice.
`default_nettype none

package spv_pkg;

  // Default sizing. The sample memory depth is a power of two.
  localparam int unsigned SAMPLE_MEM_DEPTH_DEF = 16384;
  localparam int unsigned FRAC_BITS_DEF        = 16;

  // Queue between front and back, and the result queue.
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // Input kind codes as they arrive on the kind port.
  localparam logic [2:0] KIND_LOAD  = 3'd0;
  localparam logic [2:0] KIND_TICK  = 3'd1;
  localparam logic [2:0] KIND_PLAY  = 3'd2;
  localparam logic [2:0] KIND_PAUSE = 3'd3;
  localparam logic [2:0] KIND_STOP  = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_PITCH_RATE   = 3'd0;
  localparam logic [2:0] CFG_LEFT_GAIN    = 3'd1;
  localparam logic [2:0] CFG_RIGHT_GAIN   = 3'd2;
  localparam logic [2:0] CFG_LOOP_ENABLE  = 3'd3;
  localparam logic [2:0] CFG_STEREO       = 3'd4;
  localparam logic [2:0] CFG_STREAM_MODE  = 3'd5;
  localparam logic [2:0] CFG_BLOCK_LENGTH = 3'd6;
  localparam logic [2:0] CFG_TOTAL_LENGTH = 3'd7;

  // Configuration reset values.
  localparam logic [23:0] PITCH_RATE_RST   = 24'd65536;
  localparam logic [14:0] GAIN_RST         = 15'd16384;
  localparam logic [12:0] BLOCK_LENGTH_RST = 13'd1024;
  localparam logic [31:0] TOTAL_LENGTH_RST = 32'd1024;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_TICK,
    OP_PLAY,
    OP_PAUSE,
    OP_STOP
  } op_t;

  typedef enum logic [1:0] {
    ST_STOPPED = 2'd0,
    ST_PLAYING = 2'd1,
    ST_PAUSED  = 2'd2
  } status_t;

  typedef struct packed {
    op_t                op;
    logic [13:0]        load_address;
    logic signed [15:0] load_value;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               refill_request;
    status_t            voice_status;
  } result_t;

  typedef struct packed {
    logic [23:0] pitch_rate;
    logic [14:0] gain_l;
    logic [14:0] gain_r;
    logic        loop_enable;
    logic        stereo;
    logic        stream_mode;
    logic [12:0] block_length;
    logic [31:0] total_length;
  } cfg_t;

endpackage

`default_nettype wire

/* design/spv_front.sv */
// Front end: accepts input items, classifies them and queues commands for the back end.
`default_nettype none

module spv_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [2:0]         kind,
  input  wire logic [13:0]        load_address,
  input  wire logic signed [15:0] load_value,
  output logic                    cmd_valid,
  output spv_pkg::cmd_t           cmd,
  input  wire logic               cmd_ready
);

  localparam int unsigned PTR_W = $clog2(spv_pkg::CMD_DEPTH);
  localparam int unsigned CNT_W = $clog2(spv_pkg::CMD_DEPTH + 1);

  spv_pkg::cmd_t    queue [spv_pkg::CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic          known;
  spv_pkg::op_t  op;
  logic          enq;
  logic          deq;

  always_comb begin
    known = 1'b1;
    op    = spv_pkg::OP_LOAD;
    unique case (kind)
      spv_pkg::KIND_LOAD:  op = spv_pkg::OP_LOAD;
      spv_pkg::KIND_TICK:  op = spv_pkg::OP_TICK;
      spv_pkg::KIND_PLAY:  op = spv_pkg::OP_PLAY;
      spv_pkg::KIND_PAUSE: op = spv_pkg::OP_PAUSE;
      spv_pkg::KIND_STOP:  op = spv_pkg::OP_STOP;
      default:             known = 1'b0;
    endcase
  end

  // Unknown kinds are taken off the port and dropped here.
  assign full      = (count == CNT_W'(spv_pkg::CMD_DEPTH));
  assign enq       = push && !full && known;
  assign cmd_valid = (count != '0);
  assign deq       = cmd_valid && cmd_ready;
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (enq) begin
      queue[wr_ptr] <= '{op: op, load_address: load_address, load_value: load_value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) wr_ptr <= wr_ptr + PTR_W'(1);
      if (deq) rd_ptr <= rd_ptr + PTR_W'(1);
      unique case ({enq, deq})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/spv_back.sv */
// Back end: voice state, sample memory, gain multipliers and result formation.
`default_nettype none

module spv_back #(
  parameter int unsigned SAMPLE_MEM_DEPTH = spv_pkg::SAMPLE_MEM_DEPTH_DEF,
  parameter int unsigned FRAC_BITS        = spv_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cmd_valid,
  input  wire spv_pkg::cmd_t                 cmd,
  output logic                               cmd_ready,
  input  wire spv_pkg::cfg_t                 cfg,
  input  wire logic [spv_pkg::OUT_CNT_W-1:0] out_level,
  output logic                               res_valid,
  output spv_pkg::result_t                   res
);

  localparam int unsigned AW   = $clog2(SAMPLE_MEM_DEPTH);
  localparam int unsigned HALF = SAMPLE_MEM_DEPTH / 2;
  localparam int unsigned SW   = (AW > 14 ? AW : 14) + 1;
  localparam int unsigned RW   = ((FRAC_BITS + 13) > 24 ? (FRAC_BITS + 13) : 24) + 1;
  localparam int unsigned RIW  = RW - FRAC_BITS;
  localparam int unsigned PW   = FRAC_BITS + 33;

  function automatic logic signed [15:0] scale(input logic signed [31:0] prod);
    logic signed [31:0] q;
    logic signed [31:0] r;
    q = prod + 32'sd8192;
    r = q >>> 14;
    if (r > 32'sd32767)       scale = 16'sh7fff;
    else if (r < -32'sd32768) scale = 16'sh8000;
    else                      scale = r[15:0];
  endfunction

  // Voice state.
  logic [RW-1:0]     read_pos;
  logic [PW-1:0]     play_pos;
  spv_pkg::status_t  run_status;
  logic              active_bank;

  logic [RW-1:0]     read_pos_next;
  logic [PW-1:0]     play_pos_next;
  spv_pkg::status_t  run_status_next;
  logic              active_bank_next;

  logic signed [15:0] sample_mem [SAMPLE_MEM_DEPTH];
  logic signed [15:0] rdata_a;
  logic signed [15:0] rdata_b;

  // Memory stage.
  logic              m_valid;
  logic              m_silent;
  logic              m_refill;
  logic              m_stereo;
  spv_pkg::status_t  m_status;

  // Product stage.
  logic               p_valid;
  logic signed [31:0] p_left;
  logic signed [31:0] p_right;
  logic               p_refill;
  spv_pkg::status_t   p_status;

  logic              room;
  logic              is_tick;
  logic              fire;
  logic              playing;
  logic [RW-1:0]     read_sum;
  logic [PW-1:0]     play_sum;
  logic [RIW-1:0]    read_int;
  logic              wrap;
  logic              play_end;
  logic [12:0]       idx;
  logic              bank_tick;
  logic [SW-1:0]     addr_a;
  logic [SW-1:0]     addr_b;
  logic [SW-1:0]     addr_w;
  logic signed [15:0] right_src;

  // A tick issues only when the result queue can hold it and all in flight.
  assign room = (32'(out_level) + 32'(m_valid) + 32'(p_valid)) < spv_pkg::OUT_DEPTH;
  assign is_tick   = (cmd.op == spv_pkg::OP_TICK);
  assign cmd_ready = !is_tick || room;
  assign fire      = cmd_valid && cmd_ready;
  assign playing   = (run_status == spv_pkg::ST_PLAYING);

  assign read_sum  = read_pos + RW'(cfg.pitch_rate);
  assign play_sum  = play_pos + PW'(cfg.pitch_rate);
  assign read_int  = read_sum[RW-1:FRAC_BITS];
  assign wrap      = (read_int >= RIW'(cfg.block_length));
  assign play_end  = (play_sum[PW-1:FRAC_BITS] >= 33'(cfg.total_length));
  assign idx       = wrap ? 13'd0 : read_int[12:0];
  assign bank_tick = active_bank ^ (wrap && cfg.stream_mode);

  assign addr_a = (bank_tick ? SW'(HALF) : SW'(0)) + SW'(idx);
  assign addr_b = addr_a + SW'(cfg.block_length);
  assign addr_w = SW'(cmd.load_address);

  // Next run status.
  always_comb begin
    run_status_next = run_status;
    if (fire) begin
      unique case (cmd.op)
        spv_pkg::OP_PLAY:  run_status_next = spv_pkg::ST_PLAYING;
        spv_pkg::OP_PAUSE: run_status_next = spv_pkg::ST_PAUSED;
        spv_pkg::OP_STOP:  run_status_next = spv_pkg::ST_STOPPED;
        spv_pkg::OP_TICK: begin
          if (playing && play_end) begin
            run_status_next = cfg.loop_enable ? spv_pkg::ST_PLAYING : spv_pkg::ST_STOPPED;
          end
        end
        default: run_status_next = run_status;
      endcase
    end
  end

  // Next positions and bank.
  always_comb begin
    read_pos_next    = read_pos;
    play_pos_next    = play_pos;
    active_bank_next = active_bank;
    if (fire) begin
      unique case (cmd.op)
        spv_pkg::OP_STOP: begin
          read_pos_next    = '0;
          play_pos_next    = '0;
          active_bank_next = 1'b0;
        end
        spv_pkg::OP_TICK: begin
          if (playing) begin
            active_bank_next = bank_tick;
            read_pos_next    = wrap ? '0 : read_sum;
            play_pos_next    = play_sum;
            if (play_end) begin
              read_pos_next = '0;
              play_pos_next = '0;
            end
          end
        end
        default: begin
          read_pos_next = read_pos;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_pos    <= '0;
      play_pos    <= '0;
      run_status  <= spv_pkg::ST_STOPPED;
      active_bank <= 1'b0;
    end else begin
      read_pos    <= read_pos_next;
      play_pos    <= play_pos_next;
      run_status  <= run_status_next;
      active_bank <= active_bank_next;
    end
  end

  // Sample memory: one write port for loads, two registered read ports.
  always_ff @(posedge clk) begin
    if (fire && (cmd.op == spv_pkg::OP_LOAD)) begin
      sample_mem[addr_w[AW-1:0]] <= cmd.load_value;
    end
    rdata_a <= sample_mem[addr_a[AW-1:0]];
    rdata_b <= sample_mem[addr_b[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      p_valid <= 1'b0;
    end else begin
      m_valid <= fire && is_tick;
      p_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    m_silent <= !playing;
    m_refill <= playing && wrap && cfg.stream_mode;
    m_stereo <= cfg.stereo;
    m_status <= run_status_next;
  end

  assign right_src = m_stereo ? rdata_b : rdata_a;

  always_ff @(posedge clk) begin
    p_left   <= m_silent ? 32'sd0 : rdata_a * $signed({1'b0, cfg.gain_l});
    p_right  <= m_silent ? 32'sd0 : right_src * $signed({1'b0, cfg.gain_r});
    p_refill <= m_refill;
    p_status <= m_status;
  end

  assign res_valid = p_valid;
  assign res = '{left_sample:    scale(p_left),
                 right_sample:   scale(p_right),
                 refill_request: p_refill,
                 voice_status:   p_status};

endmodule

`default_nettype wire

/* design/spv_out_queue.sv */
// Result queue that presents the oldest result on the output ports.
`default_nettype none

module spv_out_queue (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     wr_valid,
  input  wire spv_pkg::result_t         wr_data,
  output logic                          empty,
  input  wire logic                     pop,
  output spv_pkg::result_t              rd_data,
  output logic [spv_pkg::OUT_CNT_W-1:0] level
);

  localparam int unsigned PTR_W = $clog2(spv_pkg::OUT_DEPTH);
  localparam int unsigned CNT_W = spv_pkg::OUT_CNT_W;

  spv_pkg::result_t queue [spv_pkg::OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             deq;

  // The back end issues work only against free slots, so writes never overflow.
  assign empty   = (count == '0);
  assign deq     = pop && !empty;
  assign rd_data = queue[rd_ptr];
  assign level   = count;

  always_ff @(posedge clk) begin
    if (wr_valid) begin
      queue[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_valid) wr_ptr <= wr_ptr + PTR_W'(1);
      if (deq)      rd_ptr <= rd_ptr + PTR_W'(1);
      unique case ({wr_valid, deq})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/sample_playback_voice_unit.sv */
// Top level of the sample playback voice: configuration registers and module wiring.
//
//   Channel   Direction  Handshake            Payload
//   input     in         push / full          kind, load_address, load_value
//   result    out        empty / pop          left_sample, right_sample,
//                                             refill_request, voice_status
//   config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item transfer per cycle while full is low; ticks issue back to back while results drain.
// A tick's result passes the command queue head (position update, memory read),
// the gain multiply register and rounding into the result queue on its way to the result ports.
// Reset clears queues, voice state and configuration, not the sample memory.
// A stalled result side parks a tick at the back end once four results are
// queued or in flight; it blocks the command queue, which then raises full.
`default_nettype none

module sample_playback_voice_unit #(
  parameter int unsigned SAMPLE_MEM_DEPTH = spv_pkg::SAMPLE_MEM_DEPTH_DEF,
  parameter int unsigned FRAC_BITS        = spv_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [2:0]         kind,
  input  wire logic [13:0]        load_address,
  input  wire logic signed [15:0] load_value,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [15:0]      left_sample,
  output logic signed [15:0]      right_sample,
  output logic                    refill_request,
  output logic [1:0]              voice_status,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  spv_pkg::cfg_t    cfg;
  logic             cmd_valid;
  logic             cmd_ready;
  spv_pkg::cmd_t    cmd;
  logic             res_valid;
  spv_pkg::result_t res;
  spv_pkg::result_t out_data;
  logic [spv_pkg::OUT_CNT_W-1:0] out_level;

  // The register file takes a write in every cycle; software must write only while the voice is
  // idle, which the block itself does not enforce, so that no item sees a half-updated configuration.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pitch_rate   <= spv_pkg::PITCH_RATE_RST;
      cfg.gain_l       <= spv_pkg::GAIN_RST;
      cfg.gain_r       <= spv_pkg::GAIN_RST;
      cfg.loop_enable  <= 1'b0;
      cfg.stereo       <= 1'b0;
      cfg.stream_mode  <= 1'b0;
      cfg.block_length <= spv_pkg::BLOCK_LENGTH_RST;
      cfg.total_length <= spv_pkg::TOTAL_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      // Each register keeps only its own width of the write data.
      unique case (cfg_index)
        spv_pkg::CFG_PITCH_RATE:   cfg.pitch_rate   <= cfg_data[23:0];
        spv_pkg::CFG_LEFT_GAIN:    cfg.gain_l       <= cfg_data[14:0];
        spv_pkg::CFG_RIGHT_GAIN:   cfg.gain_r       <= cfg_data[14:0];
        spv_pkg::CFG_LOOP_ENABLE:  cfg.loop_enable  <= cfg_data[0];
        spv_pkg::CFG_STEREO:       cfg.stereo       <= cfg_data[0];
        spv_pkg::CFG_STREAM_MODE:  cfg.stream_mode  <= cfg_data[0];
        spv_pkg::CFG_BLOCK_LENGTH: cfg.block_length <= cfg_data[12:0];
        spv_pkg::CFG_TOTAL_LENGTH: cfg.total_length <= cfg_data;
      endcase
    end
  end

  // The front end decodes the kind and drops codes that mean nothing.
  spv_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .kind         (kind),
    .load_address (load_address),
    .load_value   (load_value),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_ready    (cmd_ready)
  );

  // The back end carries out one command per cycle; a tick waits only when the
  // result queue has no slot left for it.
  spv_back #(
    .SAMPLE_MEM_DEPTH (SAMPLE_MEM_DEPTH),
    .FRAC_BITS        (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .cfg       (cfg),
    .out_level (out_level),
    .res_valid (res_valid),
    .res       (res)
  );

  spv_out_queue u_out_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (res_valid),
    .wr_data  (res),
    .empty    (empty),
    .pop      (pop),
    .rd_data  (out_data),
    .level    (out_level)
  );

  assign left_sample    = out_data.left_sample;
  assign right_sample   = out_data.right_sample;
  assign refill_request = out_data.refill_request;
  assign voice_status   = out_data.voice_status;

endmodule

`default_nettype wire

/* design/spv_port_checker.sv */
// Port-level assertions for the sample playback voice, bound to the top level.
`default_nettype none

module spv_port_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               full,
  input wire logic               empty,
  input wire logic               pop,
  input wire logic signed [15:0] left_sample,
  input wire logic signed [15:0] right_sample,
  input wire logic               refill_request,
  input wire logic [1:0]         voice_status
);

  // Reset leaves both queues empty.
  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  // A paused voice answers ticks with silence and never swaps banks.
  a_paused_silent: assert property (@(posedge clk) disable iff (rst)
    (!empty && voice_status == spv_pkg::ST_PAUSED) |->
      (left_sample == 16'sd0 && right_sample == 16'sd0 && !refill_request))
    else $error("paused tick produced sound or a refill");

  // A refill comes only from a playing tick, which cannot leave the voice paused.
  a_refill_not_paused: assert property (@(posedge clk) disable iff (rst)
    (!empty && refill_request) |-> voice_status != spv_pkg::ST_PAUSED)
    else $error("refill request with paused status");

  // A result that is not taken stays put.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=>
      (!empty && $stable(left_sample) && $stable(right_sample) && $stable(voice_status)))
    else $error("waiting result changed");

endmodule

bind sample_playback_voice_unit spv_port_checker u_port_checker (
  .clk            (clk),
  .rst            (rst),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .left_sample    (left_sample),
  .right_sample   (right_sample),
  .refill_request (refill_request),
  .voice_status   (voice_status)
);

`default_nettype wire

/* verif/sample_playback_voice_checker.sv */
// Checker for the sample playback voice: predicts every tick's frame and compares it.
module sample_playback_voice_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire logic               full,
  input  wire logic [2:0]         kind,
  input  wire logic [13:0]        load_address,
  input  wire logic signed [15:0] load_value,
  input  wire logic               empty,
  input  wire logic               pop,
  input  wire logic signed [15:0] left_sample,
  input  wire logic signed [15:0] right_sample,
  input  wire logic               refill_request,
  input  wire logic [1:0]         voice_status,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  output int                      results_owed,
  output int                      mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MEM_WORDS  = spv_pkg::SAMPLE_MEM_DEPTH_DEF;
  localparam int unsigned BANK_WORDS = MEM_WORDS / 2;
  localparam int unsigned FRAC       = spv_pkg::FRAC_BITS_DEF;

  spv_pkg::cfg_t      settings;
  logic [63:0]        read_pos;
  logic [63:0]        play_pos;
  spv_pkg::status_t   run_state;
  logic               bank;
  logic signed [15:0] samples [MEM_WORDS];
  spv_pkg::result_t   frames_due [$];

  // Unsigned Q1.14 gain, round half up, then clamp to the 16-bit range.
  function automatic logic signed [15:0] apply_gain(logic signed [15:0] s, logic [14:0] g);
    longint q;
    q = longint'(s) * longint'(g) + 64'sd8192;
    q = q >>> 14;
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic logic signed [15:0] sample_at(logic [63:0] offset);
    logic [63:0] addr;
    addr = (64'(bank) * BANK_WORDS + offset) % MEM_WORDS;
    return samples[addr];
  endfunction

  task automatic step_voice(logic [2:0] k, logic [13:0] a, logic signed [15:0] v);
    spv_pkg::result_t   frame;
    logic [63:0]        idx;
    logic signed [15:0] left_raw;
    logic signed [15:0] right_raw;
    frame = '0;
    case (k)
      spv_pkg::KIND_LOAD:  samples[a] = v;
      spv_pkg::KIND_PLAY:  run_state = spv_pkg::ST_PLAYING;
      spv_pkg::KIND_PAUSE: run_state = spv_pkg::ST_PAUSED;
      spv_pkg::KIND_STOP: begin
        run_state = spv_pkg::ST_STOPPED;
        read_pos  = '0;
        play_pos  = '0;
        bank      = 1'b0;
      end
      spv_pkg::KIND_TICK: begin
        if (run_state == spv_pkg::ST_PLAYING) begin
          read_pos = read_pos + 64'(settings.pitch_rate);
          play_pos = play_pos + 64'(settings.pitch_rate);
          idx      = read_pos >> FRAC;
          if (idx >= 64'(settings.block_length)) begin
            if (settings.stream_mode) begin
              bank                 = ~bank;
              frame.refill_request = 1'b1;
            end
            read_pos = '0;
            idx      = '0;
          end
          // The sample still comes from the index taken before the end clears.
          if ((play_pos >> FRAC) >= 64'(settings.total_length)) begin
            play_pos = '0;
            read_pos = '0;
            if (settings.loop_enable) run_state = spv_pkg::ST_PLAYING;
            else run_state = spv_pkg::ST_STOPPED;
          end
          left_raw  = sample_at(idx);
          right_raw = settings.stereo ? sample_at(idx + 64'(settings.block_length)) : left_raw;
          frame.left_sample  = apply_gain(left_raw, settings.gain_l);
          frame.right_sample = apply_gain(right_raw, settings.gain_r);
        end
        frame.voice_status = run_state;
        frames_due.push_back(frame);
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    spv_pkg::result_t want;
    if (rst) begin
      settings = '{spv_pkg::PITCH_RATE_RST, spv_pkg::GAIN_RST, spv_pkg::GAIN_RST,
                   1'b0, 1'b0, 1'b0,
                   spv_pkg::BLOCK_LENGTH_RST, spv_pkg::TOTAL_LENGTH_RST};
      read_pos  = '0;
      play_pos  = '0;
      run_state = spv_pkg::ST_STOPPED;
      bank      = 1'b0;
      frames_due.delete();
      mismatch_count = 0;
      results_owed  <= 0;
    end else begin
      if (pop && !empty) begin
        if (frames_due.size() == 0) begin
          $display("%0t: frame with no tick waiting, expected none, actual %0d/%0d/%0b/%0d",
                   $time, left_sample, right_sample, refill_request, voice_status);
          mismatch_count++;
        end else begin
          want = frames_due.pop_front();
          compare_field("left_sample", want.left_sample, left_sample);
          compare_field("right_sample", want.right_sample, right_sample);
          compare_field("refill_request", want.refill_request, refill_request);
          compare_field("voice_status", int'(want.voice_status), voice_status);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          spv_pkg::CFG_PITCH_RATE:   settings.pitch_rate   = cfg_data[23:0];
          spv_pkg::CFG_LEFT_GAIN:    settings.gain_l       = cfg_data[14:0];
          spv_pkg::CFG_RIGHT_GAIN:   settings.gain_r       = cfg_data[14:0];
          spv_pkg::CFG_LOOP_ENABLE:  settings.loop_enable  = cfg_data[0];
          spv_pkg::CFG_STEREO:       settings.stereo       = cfg_data[0];
          spv_pkg::CFG_STREAM_MODE:  settings.stream_mode  = cfg_data[0];
          spv_pkg::CFG_BLOCK_LENGTH: settings.block_length = cfg_data[12:0];
          spv_pkg::CFG_TOTAL_LENGTH: settings.total_length = cfg_data;
          default: ;
        endcase
      end
      if (push && !full) step_voice(kind, load_address, load_value);
      results_owed <= frames_due.size();
    end
  end

endmodule

/* verif/sample_playback_voice_unit_tb.sv */
// Testbench top for the sample playback voice: stimulus, flow control and the verdict.
module sample_playback_voice_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MEM_WORDS        = spv_pkg::SAMPLE_MEM_DEPTH_DEF;
  localparam int unsigned BANK_WORDS       = MEM_WORDS / 2;
  localparam int          NUM_REGS         = 8;
  localparam int          NUM_SETUPS       = 9;
  localparam int          RANDOM_PER_SETUP = 100;
  localparam int          PRESSURE_SETUP   = 2;
  localparam int          HOLD_OFF_CYCLES  = 200;
  // Loads and status commands give nothing back, so the settle time covers
  // them with margin.
  localparam int          SETTLE_CYCLES    = 8;

  // Kind codes the block has to ignore.
  localparam logic [2:0]  KIND_UNUSED_LO   = 3'd5;
  localparam logic [2:0]  KIND_UNUSED_HI   = 3'd7;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               push         = 1'b0;
  logic               full;
  logic [2:0]         kind         = spv_pkg::KIND_LOAD;
  logic [13:0]        load_address = '0;
  logic signed [15:0] load_value   = '0;
  logic               empty;
  logic               pop          = 1'b0;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic               refill_request;
  logic [1:0]         voice_status;
  logic               cfg_valid    = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index    = spv_pkg::CFG_PITCH_RATE;
  logic [31:0]        cfg_data     = '0;

  int results_owed;
  int mismatch_count;

  // Sender burst state, sample words written since reset, and the request
  // for the receiver to go quiet for a long stretch.
  int burst_left = 0;
  bit loaded [MEM_WORDS];
  bit hold_off_req = 1'b0;

  // Voice settings, one per phase. The first one carries the directed part;
  // the others walk through the extremes of every register.
  spv_pkg::cfg_t voice_setups [NUM_SETUPS] = '{
    '{24'h010000, 15'd16384, 15'd16384, 1'b0, 1'b0, 1'b0, 13'd4,    32'd6},
    '{24'h010000, 15'd32767, 15'd0,     1'b1, 1'b0, 1'b0, 13'd16,   32'd40},
    '{24'h018000, 15'd8192,  15'd24576, 1'b1, 1'b1, 1'b1, 13'd24,   32'd100},
    '{24'hFFFFFF, 15'd16384, 15'd16384, 1'b1, 1'b1, 1'b1, 13'd32,   32'hFFFFFFFF},
    '{24'h000000, 15'd100,   15'd32767, 1'b0, 1'b0, 1'b0, 13'd4096, 32'd1},
    '{24'h004000, 15'd0,     15'd32767, 1'b1, 1'b1, 1'b1, 13'd1,    32'd3},
    '{24'h030000, 15'd20000, 15'd12000, 1'b1, 1'b1, 1'b1, 13'd0,    32'd0},
    '{24'h020000, 15'd16384, 15'd32767, 1'b1, 1'b1, 1'b1, 13'd4096, 32'd50},
    '{24'h012345, 15'd16384, 15'd16384, 1'b0, 1'b0, 1'b1, 13'd12,   32'd30}
  };

  sample_playback_voice_unit i_dut (.*);

  sample_playback_voice_checker i_checker (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Full-scale values show up often so that the gain stage saturates.
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 11))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offers one item and returns in the time step of its transfer. Items go
  // out in bursts of random length; between bursts push drops for a random
  // gap, and now and then a new burst follows with no gap at all. Push is
  // never lowered and raised in the same step.
  task automatic offer(input logic [2:0] k, input logic [13:0] a, input logic [15:0] v);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      if ($urandom_range(0, 3) != 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end
    push         <= 1'b1;
    kind         <= k;
    load_address <= a;
    load_value   <= v;
    @(posedge clk);
    while (full) @(posedge clk);
    burst_left--;
  endtask

  task automatic load_word(input int unsigned a, input logic [15:0] v);
    loaded[a] = 1'b1;
    offer(spv_pkg::KIND_LOAD, 14'(a), v);
  endtask

  // Receiver: pops in stretches of random length, each with its own pop
  // rate, from never stalling to mostly stalled. On request it holds off
  // for a long stretch so that the block fills up and raises full.
  initial begin : receiver
    int stretch;
    int rate;
    forever begin
      stretch = $urandom_range(8, 64);
      case ($urandom_range(0, 2))
        0:       rate = 100;
        1:       rate = 60;
        default: rate = 20;
      endcase
      repeat (stretch) begin
        @(posedge clk);
        if (hold_off_req) begin
          hold_off_req = 1'b0;
          pop <= 1'b0;
          repeat (HOLD_OFF_CYCLES) @(posedge clk);
        end else begin
          pop <= ($urandom_range(1, 100) <= rate);
        end
      end
    end
  end

  initial begin : stimulus
    spv_pkg::cfg_t setup;
    longint        reach;
    int            addr;
    int            pick;
    int            issued;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < NUM_SETUPS; p++) begin
      setup = voice_setups[p];
      if (p == NUM_SETUPS - 1) begin
        setup.gain_l = 15'($urandom_range(0, 32767));
        setup.gain_r = 15'($urandom_range(0, 32767));
      end

      // The block is idle here: all registers are written back to back,
      // with valid held high across the transfers.
      for (int r = 0; r < NUM_REGS; r++) begin
        cfg_valid <= 1'b1;
        cfg_index <= 3'(r);
        case (3'(r))
          spv_pkg::CFG_PITCH_RATE:   cfg_data <= 32'(setup.pitch_rate);
          spv_pkg::CFG_LEFT_GAIN:    cfg_data <= 32'(setup.gain_l);
          spv_pkg::CFG_RIGHT_GAIN:   cfg_data <= 32'(setup.gain_r);
          spv_pkg::CFG_LOOP_ENABLE:  cfg_data <= 32'(setup.loop_enable);
          spv_pkg::CFG_STEREO:       cfg_data <= 32'(setup.stereo);
          spv_pkg::CFG_STREAM_MODE:  cfg_data <= 32'(setup.stream_mode);
          spv_pkg::CFG_BLOCK_LENGTH: cfg_data <= 32'(setup.block_length);
          default:                   cfg_data <= setup.total_length;
        endcase
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
      end
      cfg_valid <= 1'b0;

      // Start every phase from a cleared voice: positions at zero, bank 0.
      offer(spv_pkg::KIND_STOP, 14'($urandom), 16'($urandom));

      // Directed part: full-scale samples at the first words and a write at
      // the top address.
      if (p == 0) begin
        load_word(0, 16'h7FFF);
        load_word(1, 16'h8000);
        load_word(2, 16'h0000);
        load_word(3, 16'hFFFF);
        load_word(MEM_WORDS - 1, 16'h5A5A);
      end

      // Every word the voice can read under this setting gets written
      // first. Positions start at zero, the read position never passes the
      // playback position, and the playback position ends at total length,
      // so the index stays below both the block length and the total length
      // plus one step.
      reach = 0;
      if (setup.block_length != 0) begin
        reach = longint'(setup.total_length == 0 ? 32'd1 : setup.total_length) +
                longint'(setup.pitch_rate >> spv_pkg::FRAC_BITS_DEF);
        if (reach > longint'(setup.block_length) - 1) reach = longint'(setup.block_length) - 1;
      end
      for (int b = 0; b <= int'(setup.stream_mode); b++) begin
        for (longint off = 0; off <= reach; off++) begin
          addr = int'((b * BANK_WORDS + off) % MEM_WORDS);
          if (!loaded[addr]) load_word(addr, pick_sample());
          if (setup.stereo) begin
            addr = int'((b * BANK_WORDS + off + setup.block_length) % MEM_WORDS);
            if (!loaded[addr]) load_word(addr, pick_sample());
          end
        end
      end

      if (p == 0) begin
        // Tick while stopped, pause from stopped, tick while paused, play twice,
        // then ticks through a block wrap and the end of the sound, which stops the
        // voice; unknown kinds must pass without a frame; then pause, stop and tick.
        offer(spv_pkg::KIND_TICK, 14'($urandom), 16'($urandom));
        offer(spv_pkg::KIND_PAUSE, 14'($urandom), 16'($urandom));
        offer(spv_pkg::KIND_TICK, 14'($urandom), 16'($urandom));
        offer(spv_pkg::KIND_PLAY, 14'($urandom), 16'($urandom));
        offer(spv_pkg::KIND_PLAY, 14'($urandom), 16'($urandom));
        repeat (7) offer(spv_pkg::KIND_TICK, 14'($urandom), 16'($urandom));
        offer(KIND_UNUSED_LO, 14'($urandom), 16'($urandom));
        offer(KIND_UNUSED_HI, 14'($urandom), 16'($urandom));
        offer(spv_pkg::KIND_PAUSE, 14'($urandom), 16'($urandom));
        offer(spv_pkg::KIND_STOP, 14'($urandom), 16'($urandom));
        offer(spv_pkg::KIND_TICK, 14'($urandom), 16'($urandom));
      end else begin
        if (p == PRESSURE_SETUP) hold_off_req = 1'b1;
        // Mostly ticks, with plays well ahead of pauses and stops so that the
        // voice spends most of its time playing through wraps and ends.
        issued = 0;
        while (issued < RANDOM_PER_SETUP) begin
          pick = $urandom_range(0, 99);
          issued++;
          if (pick < 60) begin
            offer(spv_pkg::KIND_TICK, 14'($urandom), 16'($urandom));
          end else if (pick < 72) begin
            load_word($urandom_range(0, MEM_WORDS - 1), pick_sample());
          end else if (pick < 83) begin
            offer(spv_pkg::KIND_PLAY, 14'($urandom), 16'($urandom));
          end else if (pick < 90) begin
            offer(spv_pkg::KIND_PAUSE, 14'($urandom), 16'($urandom));
          end else if (pick < 94) begin
            offer(spv_pkg::KIND_STOP, 14'($urandom), 16'($urandom));
          end else begin
            // Ignored by the block, so it does not count.
            offer(3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI)),
                  14'($urandom), 16'($urandom));
            issued--;
          end
        end
      end

      // Drain: every owed frame must arrive, then the back end gets time to
      // finish any trailing load or status command.
      push <= 1'b0;
      do @(posedge clk); while (results_owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end

    if (mismatch_count == 0) begin
      $display("[sample_playback_voice_unit] OK");
    end else begin
      $display("[sample_playback_voice_unit] ERROR");
    end
    $finish;
  end

  // The slowest correct run takes well under half a millisecond.
  initial begin : watchdog
    #5_000_000;
    $display("[sample_playback_voice_unit] ERROR");
    $finish;
  end

endmodule
